>>> design/wspid_pkg.sv
// Shared types and constants of the wheel speed PID controller.
// Holds register indexes, multiplier operand selects and the command struct.
// No dependencies.
package wspid_pkg;

	// Configuration port widths.
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 24;

	// Register indexes on the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_PROP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_INTEG     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_GAIN_DERIV     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_REF_DEADBAND   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_DRIVE_DEADBAND = 3'd5;

	// Operand pairs for the shared multiplier.
	typedef enum logic [2:0] {
		MOP_MEAS  = 3'd0,
		MOP_PROP  = 3'd1,
		MOP_DERIV = 3'd2,
		MOP_IHI   = 3'd3,
		MOP_ILO   = 3'd4
	} mul_op_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic    load_in;
		logic    mul_en;
		mul_op_t mul_op;
		logic    meas_en;
		logic    dev_en;
		logic    acc_clr;
		logic    acc_add;
		logic    tmp_en;
		logic    acc_int;
		logic    res_load;
	} wspid_cmd_t;

endpackage

>>> design/wspid_ctrl.sv
// Sequencer of the wheel speed PID controller.
// Steps one request through the datapath and owns the result valid flag.
// Depends on wspid_pkg.
module wspid_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	output logic                  out_valid,
	input  logic                  out_stall,
	input  logic                  wheel_ok,
	output wspid_pkg::wspid_cmd_t cmd
);
	import wspid_pkg::*;

	typedef enum logic [9:0] {
		ST_IDLE     = 10'b0000000001,
		ST_MUL_MEAS = 10'b0000000010,
		ST_MEAS     = 10'b0000000100,
		ST_DEV      = 10'b0000001000,
		ST_MUL_P    = 10'b0000010000,
		ST_MUL_D    = 10'b0000100000,
		ST_MUL_IH   = 10'b0001000000,
		ST_MUL_IL   = 10'b0010000000,
		ST_ACC_I    = 10'b0100000000,
		ST_FIN      = 10'b1000000000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;

	// Next state and datapath commands.
	always_comb begin
		state_d      = state_q;
		cmd.load_in  = 1'b0;
		cmd.mul_en   = 1'b0;
		cmd.mul_op   = MOP_MEAS;
		cmd.meas_en  = 1'b0;
		cmd.dev_en   = 1'b0;
		cmd.acc_clr  = 1'b0;
		cmd.acc_add  = 1'b0;
		cmd.tmp_en   = 1'b0;
		cmd.acc_int  = 1'b0;
		cmd.res_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load_in = 1'b1;
					state_d     = ST_MUL_MEAS;
				end
			end
			ST_MUL_MEAS: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MOP_MEAS;
				state_d    = ST_MEAS;
			end
			ST_MEAS: begin
				cmd.meas_en = 1'b1;
				state_d     = ST_DEV;
			end
			ST_DEV: begin
				// A sample for a wheel that does not exist goes straight to the result.
				if (wheel_ok) begin
					cmd.dev_en = 1'b1;
					state_d    = ST_MUL_P;
				end else begin
					state_d = ST_FIN;
				end
			end
			ST_MUL_P: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_op  = MOP_PROP;
				cmd.acc_clr = 1'b1;
				state_d     = ST_MUL_D;
			end
			ST_MUL_D: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_op  = MOP_DERIV;
				cmd.acc_add = 1'b1;
				state_d     = ST_MUL_IH;
			end
			ST_MUL_IH: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_op  = MOP_IHI;
				cmd.acc_add = 1'b1;
				state_d     = ST_MUL_IL;
			end
			ST_MUL_IL: begin
				cmd.mul_en = 1'b1;
				cmd.mul_op = MOP_ILO;
				cmd.tmp_en = 1'b1;
				state_d    = ST_ACC_I;
			end
			ST_ACC_I: begin
				cmd.acc_int = 1'b1;
				state_d     = ST_FIN;
			end
			ST_FIN: begin
				// Wait until the output register is free.
				if (!out_valid_q || !out_stall) begin
					cmd.res_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// State register and result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.res_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

>>> design/wspid_dp.sv
// Datapath of the wheel speed PID controller.
// Holds configuration, per-wheel state, one shared multiplier and the result register.
// Depends on wspid_pkg.
module wspid_dp #(
	parameter int NUM_WHEELS = 3
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  wspid_pkg::wspid_cmd_t                cmd,
	output logic                                 wheel_ok,
	input  logic                                 cfg_we,
	input  logic [wspid_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [wspid_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [1:0]                           wheel,
	input  logic signed [19:0]                   speed_ref,
	input  logic signed [15:0]                   encoder_delta,
	output logic [1:0]                           wheel_out,
	output logic signed [15:0]                   drive,
	output logic signed [19:0]                   measured_speed,
	output logic                                 clamped
);
	import wspid_pkg::*;

	localparam int WIDX = (NUM_WHEELS > 1) ? $clog2(NUM_WHEELS) : 1;

	localparam logic signed [65:0] PROD_LIM = 66'sd1 <<< 40;
	localparam logic signed [42:0] ONE_Q28  = 43'sd1 <<< 28;

	// Saturate to 20 bits signed.
	function automatic logic signed [19:0] sat20(input logic signed [32:0] x);
		logic signed [32:0] hi;
		logic signed [32:0] lo;
		hi = 33'sd524287;
		lo = -33'sd524288;
		if (x > hi) return 20'sh7FFFF;
		if (x < lo) return 20'sh80000;
		return x[19:0];
	endfunction

	// Saturate to 40 bits signed.
	function automatic logic signed [39:0] sat40(input logic signed [41:0] x);
		logic signed [41:0] hi;
		logic signed [41:0] lo;
		hi = 42'sh0_7F_FFFF_FFFF;
		lo = -42'sh0_80_0000_0000;
		if (x > hi) return {1'b0, {39{1'b1}}};
		if (x < lo) return {1'b1, {39{1'b0}}};
		return x[39:0];
	endfunction

	// Limit a gain product to plus or minus 2^40.
	function automatic logic signed [41:0] sat_prod(input logic signed [65:0] x);
		if (x > PROD_LIM) return PROD_LIM[41:0];
		if (x < -PROD_LIM) return 42'(-PROD_LIM);
		return x[41:0];
	endfunction

	// Configuration registers.
	logic [23:0] speed_scale_q;
	logic [23:0] gain_prop_q;
	logic [23:0] gain_integ_q;
	logic [23:0] gain_deriv_q;
	logic [18:0] ref_deadband_q;
	logic [14:0] drive_deadband_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			speed_scale_q    <= 24'd45748;
			gain_prop_q      <= 24'd83886;
			gain_integ_q     <= 24'd1049;
			gain_deriv_q     <= 24'd419430;
			ref_deadband_q   <= 19'd1024;
			drive_deadband_q <= 15'd3277;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SPEED_SCALE:    speed_scale_q    <= cfg_data;
				REG_GAIN_PROP:      gain_prop_q      <= cfg_data;
				REG_GAIN_INTEG:     gain_integ_q     <= cfg_data;
				REG_GAIN_DERIV:     gain_deriv_q     <= cfg_data;
				REG_REF_DEADBAND:   ref_deadband_q   <= cfg_data[18:0];
				REG_DRIVE_DEADBAND: drive_deadband_q <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	// Captured request.
	logic [1:0]          wheel_q;
	logic signed [19:0]  ref_q;
	logic signed [15:0]  enc_q;
	logic [WIDX-1:0]     widx;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			wheel_q <= wheel;
			ref_q   <= speed_ref;
			enc_q   <= encoder_delta;
		end
	end

	assign wheel_ok = (32'(wheel_q) < NUM_WHEELS);
	assign widx     = WIDX'(wheel_q);

	// Per-wheel integral and previous deviation.
	logic signed [39:0] integ_q [NUM_WHEELS];
	logic signed [20:0] prev_q  [NUM_WHEELS];

	// Working registers.
	logic signed [46:0] prod_q;
	logic signed [19:0] meas_q;
	logic signed [20:0] dev_q;
	logic signed [21:0] diff_q;
	logic signed [39:0] sum_q;
	logic signed [64:0] tmp_q;
	logic signed [42:0] acc_q;

	// Shared multiplier: unsigned 24-bit factor times signed 22-bit operand.
	logic signed [24:0] mul_a;
	logic signed [21:0] mul_b;
	logic signed [46:0] mul_p;

	always_comb begin
		case (cmd.mul_op)
			MOP_MEAS: begin
				mul_a = $signed({1'b0, speed_scale_q});
				mul_b = {{6{enc_q[15]}}, enc_q};
			end
			MOP_PROP: begin
				mul_a = $signed({1'b0, gain_prop_q});
				mul_b = {dev_q[20], dev_q};
			end
			MOP_DERIV: begin
				mul_a = $signed({1'b0, gain_deriv_q});
				mul_b = diff_q;
			end
			MOP_IHI: begin
				mul_a = $signed({1'b0, gain_integ_q});
				mul_b = {{2{sum_q[39]}}, sum_q[39:20]};
			end
			MOP_ILO: begin
				mul_a = $signed({1'b0, gain_integ_q});
				mul_b = $signed({2'b00, sum_q[19:0]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	// Measured speed: round half up, then saturate. The product fits in 41 bits
	// with its sign, so the low 41 bits carry it exactly.
	logic signed [40:0] meas_rnd;
	assign meas_rnd = prod_q[40:0] + 41'sd128;

	// Reference deadband and deviation terms.
	logic signed [20:0] ref_neg;
	logic [19:0]        ref_mag;
	logic signed [19:0] ref_z;
	logic signed [20:0] dev_c;
	logic signed [41:0] sum_w;

	assign ref_neg = -21'(ref_q);
	assign ref_mag = ref_q[19] ? ref_neg[19:0] : ref_q;
	assign ref_z   = (ref_mag < 20'(ref_deadband_q)) ? 20'sd0 : ref_q;
	assign dev_c   = 21'(ref_z) - 21'(meas_q);
	assign sum_w   = 42'(integ_q[widx]) + 42'(dev_c) + 42'(prev_q[widx]);

	// Integral product: high partial product shifted up plus the low one.
	logic signed [65:0] integ_full;
	assign integ_full = 66'(tmp_q) + 66'(prod_q);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.meas_en) begin
			meas_q <= sat20(meas_rnd[40:8]);
		end
		if (cmd.dev_en) begin
			dev_q  <= dev_c;
			diff_q <= 22'(dev_c) - 22'(prev_q[widx]);
			sum_q  <= sat40(sum_w);
		end
		if (cmd.tmp_en) begin
			tmp_q <= {prod_q[44:0], 20'd0};
		end
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (cmd.acc_add) begin
			acc_q <= acc_q + 43'(sat_prod(66'(prod_q)));
		end else if (cmd.acc_int) begin
			acc_q <= acc_q + 43'(sat_prod(integ_full));
		end
	end

	// Drive: clamp to full scale, round, then apply the drive deadband.
	logic signed [42:0] drv_rnd;
	logic signed [15:0] drv_lim;
	logic               drv_clamp;
	logic signed [15:0] drv_neg;
	logic [15:0]        drv_mag;
	logic signed [15:0] drv_fin;

	assign drv_rnd = acc_q + 43'sd8192;

	always_comb begin
		if (acc_q > ONE_Q28) begin
			drv_lim   = 16'sd16384;
			drv_clamp = 1'b1;
		end else if (acc_q < -ONE_Q28) begin
			drv_lim   = -16'sd16384;
			drv_clamp = 1'b1;
		end else begin
			drv_lim   = drv_rnd[29:14];
			drv_clamp = 1'b0;
		end
	end

	assign drv_neg = -drv_lim;
	assign drv_mag = drv_lim[15] ? drv_neg : drv_lim;
	assign drv_fin = (drv_mag < 16'(drive_deadband_q)) ? 16'sd0 : drv_lim;

	// Per-wheel state update at the end of a valid sample.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_WHEELS; i++) begin
				integ_q[i] <= '0;
				prev_q[i]  <= '0;
			end
		end else if (cmd.res_load && wheel_ok) begin
			integ_q[widx] <= sum_q;
			prev_q[widx]  <= dev_q;
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			wheel_out      <= wheel_q;
			measured_speed <= meas_q;
			drive          <= wheel_ok ? drv_fin : 16'sd0;
			clamped        <= wheel_ok ? drv_clamp : 1'b0;
		end
	end

endmodule

>>> design/wheel_speed_pid_with_deadbands.sv
// Top level of the three-wheel PID speed controller with deadbands.
// Joins the sequencer wspid_ctrl and the datapath wspid_dp; uses wspid_pkg.
//
//   channel   signals                                     handshake
//   input     wheel, speed_ref, encoder_delta             in_valid / in_stall
//   result    wheel_out, drive, measured_speed, clamped   out_valid / out_stall
//   config    cfg_index, cfg_data                         cfg_valid / cfg_ready
//
// A request for a known wheel steps through the speed product, measured speed,
// deviation, P, D, high and low I products, integral sum and the final step,
// which loads the result; an unknown wheel skips from deviation to the final
// step. The single shared multiplier is used five times in turn for a known
// wheel. One request is in work at a time, while the output register holds the
// previous result. A stalled result holds the sequencer in its final step.
// Reset clears wheel state, loads register defaults and leaves the block ready.
module wheel_speed_pid_with_deadbands #(
	parameter int NUM_WHEELS = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [1:0]                       wheel,
	input  logic signed [19:0]               speed_ref,
	input  logic signed [15:0]               encoder_delta,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic [1:0]                       wheel_out,
	output logic signed [15:0]               drive,
	output logic signed [19:0]               measured_speed,
	output logic                             clamped,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [wspid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wspid_pkg::CFG_DATA_W-1:0] cfg_data
);
	import wspid_pkg::*;

	wspid_cmd_t cmd;
	logic       wheel_ok;

	// Register writes are taken in every cycle.
	assign cfg_ready = 1'b1;

	wspid_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.wheel_ok  (wheel_ok),
		.cmd       (cmd)
	);

	wspid_dp #(
		.NUM_WHEELS (NUM_WHEELS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.wheel_ok       (wheel_ok),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.wheel          (wheel),
		.speed_ref      (speed_ref),
		.encoder_delta  (encoder_delta),
		.wheel_out      (wheel_out),
		.drive          (drive),
		.measured_speed (measured_speed),
		.clamped        (clamped)
	);

endmodule

>>> bench/wspid_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the wheel speed PID controller: tracks register writes, predicts
// one drive result per accepted request and compares it with the block's output.
// Depends on wspid_pkg for the register indexes and the port widths.
module wspid_checker #(
	parameter int NUM_WHEELS = 3
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	input  logic                             in_stall,
	input  logic [1:0]                       wheel,
	input  logic signed [19:0]               speed_ref,
	input  logic signed [15:0]               encoder_delta,
	input  logic                             out_valid,
	input  logic                             out_stall,
	input  logic [1:0]                       wheel_out,
	input  logic signed [15:0]               drive,
	input  logic signed [19:0]               measured_speed,
	input  logic                             clamped,
	input  logic                             cfg_valid,
	input  logic                             cfg_ready,
	input  logic [wspid_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [wspid_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                               mismatches,
	output int                               pending
);
	import wspid_pkg::*;

	localparam longint DRIVE_FULL  = 16384;
	localparam longint ONE_Q28     = longint'(1) << 28;
	localparam longint PRODUCT_CAP = longint'(1) << 40;
	localparam int     MAX_PRINTED = 100;

	typedef struct {
		logic [1:0]         wheel;
		logic signed [15:0] drive;
		logic signed [19:0] speed;
		logic               clamped;
	} drive_result_t;

	// Shadow copy of the registers and of the per-wheel loop state.
	logic [23:0] speed_scale;
	logic [23:0] gain_prop;
	logic [23:0] gain_integ;
	logic [23:0] gain_deriv;
	logic [18:0] ref_deadband;
	logic [14:0] drive_deadband;
	longint      integ_sum [NUM_WHEELS];
	longint      prev_dev [NUM_WHEELS];

	drive_result_t expected_drives [$];

	function automatic longint saturate(longint x, int bits);
		longint hi;
		longint lo;
		hi = (longint'(1) << (bits - 1)) - 1;
		lo = -hi - 1;
		if (x > hi)
			return hi;
		if (x < lo)
			return lo;
		return x;
	endfunction

	function automatic longint clip_product(longint x);
		if (x > PRODUCT_CAP)
			return PRODUCT_CAP;
		if (x < -PRODUCT_CAP)
			return -PRODUCT_CAP;
		return x;
	endfunction

	// One PID update for one wheel; advances that wheel's integral and history.
	function automatic drive_result_t predict_drive(logic [1:0] w, logic signed [19:0] sref,
			logic signed [15:0] cnt);
		drive_result_t r;
		longint speed;
		longint target;
		longint dev;
		longint sum;
		longint diff;
		longint total;
		longint level;
		longint mag;
		speed = saturate((longint'(cnt) * longint'(speed_scale) + 128) >>> 8, 20);
		r.wheel = w;
		r.speed = speed[19:0];
		r.drive = '0;
		r.clamped = 1'b0;
		// An unknown wheel reports its speed only and leaves all state alone.
		if (w >= NUM_WHEELS)
			return r;
		target = sref;
		mag = (target < 0) ? -target : target;
		if (mag < longint'(ref_deadband))
			target = 0;
		dev = target - speed;
		sum = saturate(integ_sum[w] + dev + prev_dev[w], 40);
		diff = dev - prev_dev[w];
		total = clip_product(longint'(gain_prop) * dev)
			+ clip_product(longint'(gain_integ) * sum)
			+ clip_product(longint'(gain_deriv) * diff);
		if (total > ONE_Q28) begin
			level = DRIVE_FULL;
			r.clamped = 1'b1;
		end else if (total < -ONE_Q28) begin
			level = -DRIVE_FULL;
			r.clamped = 1'b1;
		end else begin
			level = (total + 8192) >>> 14;
		end
		// The output deadband applies after the limit, so clamped may stay set.
		mag = (level < 0) ? -level : level;
		if (mag < longint'(drive_deadband))
			level = 0;
		integ_sum[w] = sum;
		prev_dev[w] = dev;
		r.drive = level[15:0];
		return r;
	endfunction

	task automatic report_mismatch(string msg);
		if (mismatches < MAX_PRINTED)
			$display("%0t ns mismatch: %s", $time, msg);
		mismatches++;
	endtask

	task automatic compare_field(string name, logic [19:0] got, logic [19:0] want);
		if (got !== want)
			report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
	endtask

	// Results are checked before new requests are queued, since a result
	// accepted at an edge never belongs to a request accepted at that edge.
	always @(posedge clk or negedge arst_n) begin
		drive_result_t want;
		if (!arst_n) begin
			speed_scale = 24'd45748;
			gain_prop = 24'd83886;
			gain_integ = 24'd1049;
			gain_deriv = 24'd419430;
			ref_deadband = 19'd1024;
			drive_deadband = 15'd3277;
			for (int i = 0; i < NUM_WHEELS; i++) begin
				integ_sum[i] = 0;
				prev_dev[i] = 0;
			end
			expected_drives.delete();
			mismatches = 0;
			pending = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_drives.size() == 0) begin
					report_mismatch($sformatf("result for wheel %0d with no request open",
						wheel_out));
				end else begin
					want = expected_drives.pop_front();
					compare_field("wheel_out", 20'(wheel_out), 20'(want.wheel));
					compare_field("drive", 20'(drive), 20'(want.drive));
					compare_field("measured_speed", measured_speed, want.speed);
					compare_field("clamped", 20'(clamped), 20'(want.clamped));
				end
			end
			if (in_valid && !in_stall)
				expected_drives.push_back(predict_drive(wheel, speed_ref, encoder_delta));
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_SPEED_SCALE:    speed_scale = cfg_data;
					REG_GAIN_PROP:      gain_prop = cfg_data;
					REG_GAIN_INTEG:     gain_integ = cfg_data;
					REG_GAIN_DERIV:     gain_deriv = cfg_data;
					REG_REF_DEADBAND:   ref_deadband = cfg_data[18:0];
					REG_DRIVE_DEADBAND: drive_deadband = cfg_data[14:0];
					default: ;
				endcase
			end
			pending = expected_drives.size();
		end
	end

endmodule

>>> bench/wheel_speed_pid_with_deadbands_tb.sv
`timescale 1ns / 100ps
// Top of the wheel speed PID controller bench: clock, reset, register settings
// and paced requests, with the result checking done by wspid_checker.
// Depends on wspid_pkg, wheel_speed_pid_with_deadbands and wspid_checker.
module wheel_speed_pid_with_deadbands_tb;
	import wspid_pkg::*;

	localparam int NUM_WHEELS      = 3;
	localparam int CYCLE_LIMIT     = 400000;
	localparam int SETTLE_CYCLES   = 20;
	localparam int PHASES          = 9;
	localparam int ITEMS_PER_PHASE = 200;

	// Indexes past the last register; writes to them must change nothing.
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic [1:0]            wheel = '0;
	logic signed [19:0]    speed_ref = '0;
	logic signed [15:0]    encoder_delta = '0;
	logic                  out_stall = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic                  in_stall;
	logic                  out_valid;
	logic [1:0]            wheel_out;
	logic signed [15:0]    drive;
	logic signed [19:0]    measured_speed;
	logic                  clamped;
	logic                  cfg_ready;

	int                    mismatches;
	int                    pending;
	int                    cycles = 0;
	int                    send_idle_pct = 0;
	int                    recv_idle_pct = 0;
	logic [18:0]           cur_ref_deadband = 19'd1024;

	wheel_speed_pid_with_deadbands #(
		.NUM_WHEELS(NUM_WHEELS)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.wheel(wheel),
		.speed_ref(speed_ref),
		.encoder_delta(encoder_delta),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.wheel_out(wheel_out),
		.drive(drive),
		.measured_speed(measured_speed),
		.clamped(clamped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	wspid_checker #(
		.NUM_WHEELS(NUM_WHEELS)
	) u_scoreboard (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.wheel(wheel),
		.speed_ref(speed_ref),
		.encoder_delta(encoder_delta),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.wheel_out(wheel_out),
		.drive(drive),
		.measured_speed(measured_speed),
		.clamped(clamped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.mismatches(mismatches),
		.pending(pending)
	);

	always #4 clk = ~clk;

	// The result side stalls at random, one decision per cycle.
	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < recv_idle_pct);
	end

	// Watchdog against a hung handshake or a lost result.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	task automatic set_pacing(int mode);
		case (mode)
			0: begin
				send_idle_pct = 23;
				recv_idle_pct = 70;
			end
			1: begin
				send_idle_pct = 70;
				recv_idle_pct = 23;
			end
			default: begin
				send_idle_pct = 0;
				recv_idle_pct = 0;
			end
		endcase
	endtask

	// Offers one request, after a random gap, and returns at the edge that takes it.
	// The stall is looked at on the falling edge, where it is settled.
	task automatic send_sample(logic [1:0] w, logic [19:0] sref, logic [15:0] cnt);
		logic taken;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		wheel <= w;
		speed_ref <= sref;
		encoder_delta <= cnt;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = !in_stall;
			@(posedge clk);
		end
	endtask

	// Leaves cfg_valid high so that back-to-back writes need one assignment per edge.
	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		logic taken;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		taken = 1'b0;
		while (!taken) begin
			@(negedge clk);
			taken = cfg_ready;
			@(posedge clk);
		end
	endtask

	// Holds off new requests until every result is in and the block has settled.
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	function automatic logic [23:0] random_gain();
		return 24'($urandom_range((32'd1 << $urandom_range(23, 8)) - 1, 0));
	endfunction

	// Register set for one phase: all ones with a full-scale drive deadband, all zeros,
	// an oversize drive deadband with writes to spare indexes, or a random working point.
	task automatic apply_setting(int phase);
		logic [23:0] scale;
		logic [23:0] kp;
		logic [23:0] ki;
		logic [23:0] kd;
		logic [18:0] rdb;
		logic [14:0] ddb;
		case (phase)
			1: begin
				scale = '1;
				kp = '1;
				ki = '1;
				kd = '1;
				rdb = '1;
				ddb = 15'd16384;
			end
			2: begin
				scale = '0;
				kp = '0;
				ki = '0;
				kd = '0;
				rdb = '0;
				ddb = '0;
			end
			3: begin
				scale = 24'($urandom_range(100000, 1));
				kp = random_gain();
				ki = random_gain();
				kd = random_gain();
				rdb = 19'($urandom_range(2048));
				ddb = '1;
			end
			default: begin
				scale = 24'($urandom_range(200000, 1));
				kp = random_gain();
				ki = random_gain();
				kd = random_gain();
				rdb = 19'($urandom_range(4096));
				ddb = 15'($urandom_range(4000));
			end
		endcase
		write_reg(REG_SPEED_SCALE, scale);
		write_reg(REG_GAIN_PROP, kp);
		write_reg(REG_GAIN_INTEG, ki);
		write_reg(REG_GAIN_DERIV, kd);
		write_reg(REG_REF_DEADBAND, 24'(rdb));
		write_reg(REG_DRIVE_DEADBAND, 24'(ddb));
		if (phase == 3) begin
			write_reg(REG_SPARE_LO, 24'($urandom));
			write_reg(REG_SPARE_HI, '1);
		end
		cfg_valid <= 1'b0;
		cur_ref_deadband = rdb;
	endtask

	// Random request: full-range noise, small tracking errors, references at the
	// deadband edge, or moderate speeds; a few go to the unused wheel number.
	task automatic send_random_sample();
		logic [1:0] w;
		logic [19:0] sref;
		logic [15:0] cnt;
		int a;
		int b;
		w = ($urandom_range(15) == 0) ? 2'd3 : 2'($urandom_range(NUM_WHEELS - 1));
		case ($urandom_range(3))
			0: begin
				a = int'($urandom);
				b = int'($urandom);
			end
			1: begin
				a = int'($urandom_range(6000)) - 3000;
				b = int'($urandom_range(40)) - 20;
			end
			2: begin
				a = int'(cur_ref_deadband) + int'($urandom_range(8)) - 4;
				if ($urandom_range(1) == 1)
					a = -a;
				b = int'($urandom_range(400)) - 200;
			end
			default: begin
				a = int'($urandom_range(80000)) - 40000;
				b = int'($urandom_range(4000)) - 2000;
			end
		endcase
		sref = a[19:0];
		cnt = b[15:0];
		send_sample(w, sref, cnt);
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed requests under the reset register values.
		set_pacing(0);
		send_sample(2'd0, 20'h00000, 16'h0000);
		send_sample(2'd0, 20'h7FFFF, 16'h0000);
		send_sample(2'd0, 20'h80000, 16'h0000);
		send_sample(2'd1, 20'h00000, 16'h7FFF);
		send_sample(2'd1, 20'h00000, 16'h8000);
		send_sample(2'd2, 20'h7FFFF, 16'h8000);
		send_sample(2'd2, 20'h80000, 16'h7FFF);
		send_sample(2'd0, 20'd1023, 16'h0000);
		send_sample(2'd0, 20'd1024, 16'h0000);
		send_sample(2'd1, -20'sd1023, 16'h0000);
		send_sample(2'd1, -20'sd1024, 16'h0000);
		send_sample(2'd3, 20'd5000, 16'd1000);
		send_sample(2'd3, 20'h80000, 16'h8000);
		send_sample(2'd2, 20'd2000, 16'd10);
		send_sample(2'd2, 20'd2000, 16'd11);
		send_sample(2'd2, 20'd2000, 16'd12);
		send_sample(2'd0, 20'd3000, 16'd16);
		send_sample(2'd0, 20'd3000, 16'd17);
		send_sample(2'd0, 20'd3000, 16'd17);
		send_sample(2'd1, -20'sd1500, -16'sd8);
		send_sample(2'd1, -20'sd1500, -16'sd9);
		send_sample(2'd2, 20'd0, 16'd1);
		send_sample(2'd2, 20'd0, -16'sd1);
		send_sample(2'd0, 20'h55555, 16'hAAAA);
		drain_results();

		// Random phases, each with its own register set and pacing.
		for (int phase = 0; phase < PHASES; phase++) begin
			set_pacing(phase % 3);
			apply_setting(phase);
			for (int i = 0; i < ITEMS_PER_PHASE; i++) begin
				send_random_sample();
				if (i == ITEMS_PER_PHASE / 2 || $urandom_range(149) == 0)
					drain_results();
			end
			drain_results();
		end

		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

>>> filelist.f
design/wspid_pkg.sv
design/wspid_ctrl.sv
design/wspid_dp.sv
design/wheel_speed_pid_with_deadbands.sv
bench/wspid_checker.sv
bench/wheel_speed_pid_with_deadbands_tb.sv
